// ===== design/assert_macros.svh =====
// Assertion macros used by the sorter controller; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Expression holds at every clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: check failed");
// Consequent holds in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define CHK_ALWAYS(lbl, clk, rst, expr)
`define CHK_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/ris_pkg.sv =====
// Types and constants of the record insertion sorter.
package ris_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 64;
  localparam int TAG_W    = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // One input transaction.
  typedef struct packed {
    logic [KEY_W-1:0] sort_key;
    logic [TAG_W-1:0] record_tag;
    logic             last_record;
  } in_rec_t;

  // One output transaction.
  typedef struct packed {
    logic [KEY_W-1:0] out_key;
    logic [TAG_W-1:0] out_tag;
    logic             out_last;
    logic             overflowed;
  } out_rec_t;

  // Record held in one cell of the chain.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  // Commands from the controller to every cell.
  typedef struct packed {
    logic capture;  // compare stored key against the arriving key
    logic insert;   // open a slot and write the new record
    logic drain;    // shift every record one cell toward the head
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_DRAIN
  } state_t;

endpackage

// ===== design/ris_cell.sv =====
// One cell of the sort chain: a stored record, its compare flag and its shift mux.
module ris_cell (
  input  logic                    clk,
  input  ris_pkg::cell_ctl_t      ctl,
  input  logic                    descending,
  input  logic [ris_pkg::KEY_W-1:0] cmp_key,
  input  logic                    occupied,
  input  ris_pkg::rec_t           new_rec,
  input  ris_pkg::rec_t           prev_rec,
  input  ris_pkg::rec_t           next_rec,
  input  logic                    run_here,
  input  logic                    run_prev,
  output ris_pkg::rec_t           rec,
  output logic                    behind
);
  import ris_pkg::*;

  logic key_behind;

  // The stored record must move back when the arriving key ranks strictly ahead.
  assign key_behind = descending ? (rec.key < cmp_key) : (rec.key > cmp_key);

  // An empty cell always counts as behind, so the run reaches the end of the chain.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      behind <= !occupied || key_behind;
    end
  end

  // Inside the run every record steps back one cell; the first cell of the run
  // takes the new record. Draining moves records toward the head.
  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (run_prev) begin
        rec <= prev_rec;
      end else if (run_here) begin
        rec <= new_rec;
      end
    end else if (ctl.drain) begin
      rec <= next_rec;
    end
  end

endmodule

// ===== design/ris_ctrl.sv =====
// Sequencer of the sorter: input capture, sort order, fill count, overflow flag and output register.
`include "assert_macros.svh"
module ris_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ris_pkg::in_rec_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ris_pkg::out_rec_t         out_data,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  input  ris_pkg::rec_t             head_rec,
  output ris_pkg::cell_ctl_t        ctl,
  output logic                      descending,
  output ris_pkg::rec_t             new_rec,
  output logic [ris_pkg::CNT_W-1:0] fill
);
  import ris_pkg::*;

  state_t state;
  state_t state_next;
  logic   drop_flag;
  logic   last_pending;
  logic   load;
  logic   full;
  logic   final_load;

  assign full       = (fill == CNT_W'(CAPACITY));
  assign final_load = load && (fill == CNT_W'(1));

  // Next state and cell commands.
  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    load       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = ST_INSERT;
        end
      end
      ST_INSERT: begin
        ctl.insert = !full;
        state_next = last_pending ? ST_DRAIN : ST_IDLE;
      end
      ST_DRAIN: begin
        load      = !out_valid || out_ready;
        ctl.drain = load;
        if (final_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sort order register.
  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b1;
    end else if (cfg_we) begin
      descending <= cfg_wdata;
    end
  end

  // Arriving record, held for the insert cycle.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      new_rec.key  <= in_data.sort_key;
      new_rec.tag  <= in_data.record_tag;
      last_pending <= in_data.last_record;
    end
  end

  // Fill count and overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      drop_flag <= 1'b0;
    end else if (ctl.insert) begin
      fill <= fill + CNT_W'(1);
    end else if (state == ST_INSERT && full) begin
      drop_flag <= 1'b1;
    end else if (load) begin
      fill <= fill - CNT_W'(1);
      if (final_load) begin
        drop_flag <= 1'b0;
      end
    end
  end

  // Output register: the head cell is copied here as the chain shifts.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_key    <= head_rec.key;
      out_data.out_tag    <= head_rec.tag;
      out_data.out_last   <= final_load;
      out_data.overflowed <= drop_flag;
    end
  end

  `CHK_ALWAYS(fill_in_range, clk, rst, fill <= CNT_W'(CAPACITY))
  `CHK_ALWAYS(drain_not_empty, clk, rst, (state != ST_DRAIN) || (fill != '0))
  `CHK_NEXT(accept_goes_insert, clk, rst, in_valid && in_ready, state == ST_INSERT)
  `CHK_NEXT(full_sets_drop, clk, rst, (state == ST_INSERT) && full, drop_flag)

endmodule

// ===== design/record_insertion_sorter_top.sv =====
// Top level of the record insertion sorter: a chain of sort cells and its sequencer.
//
//   channel  | signals                    | contents
//   ---------+----------------------------+-----------------------------------
//   input    | in_valid, in_ready, in_data | sort_key, record_tag, last_record
//   output   | out_valid, out_ready, out_data | out_key, out_tag, out_last, overflowed
//   config   | cfg_we, cfg_wdata          | sort_descending
//
// Each record passes a capture step, where every cell compares its key with the
// arriving key, then an insert step that opens a slot and shifts in parallel.
// A record marked last then drains the chain, one result per cycle while
// out_ready is high; input is held off until the last result is registered.
// Reset clears the fill count, overflow flag and output valid; there is no
// clearing pass. A stalled output holds the chain in place.
module record_insertion_sorter_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ris_pkg::in_rec_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ris_pkg::out_rec_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  import ris_pkg::*;

  cell_ctl_t        ctl;
  logic             descending;
  rec_t             new_rec;
  logic [CNT_W-1:0] fill;
  rec_t             recs [CAPACITY];
  logic [CAPACITY-1:0] behind;
  logic [CAPACITY-1:0] run;

  ris_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_rec   (recs[0]),
    .ctl        (ctl),
    .descending (descending),
    .new_rec    (new_rec),
    .fill       (fill)
  );

  // A cell is in the run when it and every cell after it go behind the new key.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rec_t prev_rec;
    rec_t next_rec;
    logic run_prev;

    assign run[i] = &behind[CAPACITY-1:i];

    if (i == 0) begin : g_head
      assign prev_rec = '0;
      assign run_prev = 1'b0;
    end else begin : g_body
      assign prev_rec = recs[i-1];
      assign run_prev = run[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_rec = '0;
    end else begin : g_inner
      assign next_rec = recs[i+1];
    end

    ris_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .descending (descending),
      .cmp_key    (in_data.sort_key),
      .occupied   (fill > CNT_W'(i)),
      .new_rec    (new_rec),
      .prev_rec   (prev_rec),
      .next_rec   (next_rec),
      .run_here   (run[i]),
      .run_prev   (run_prev),
      .rec        (recs[i]),
      .behind     (behind[i])
    );
  end

endmodule
